>>> rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the reflow profile controller
// Holds the event and phase codes, the configuration and state records,
// the profile breakpoints and the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

	// Event codes carried by the kind field of a request.
	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_START  = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	// Oven phases. Codes 6 and 7 are never entered.
	typedef enum logic [2:0] {
		PH_OFF     = 3'd0,
		PH_PREHEAT = 3'd1,
		PH_SOAK    = 3'd2,
		PH_RISE    = 3'd3,
		PH_FALL    = 3'd4,
		PH_COOL    = 3'd5
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GAIN       = 2'd0,
		CFG_FULL_ERROR = 2'd1,
		CFG_DUTY_FULL  = 2'd2,
		CFG_DONE_SEC   = 2'd3
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 17;

	typedef struct packed {
		logic [14:0] gain;
		logic [14:0] full_on_error;
		logic [15:0] duty_full;
		logic [16:0] done_seconds;
	} rpc_cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [16:0]        seconds;
		logic [15:0]        duty;
		logic signed [15:0] target;
		logic               buzzer;
	} rpc_state_t;

	localparam logic [14:0] GAIN_RST       = 15'd400;
	localparam logic [14:0] FULL_ERROR_RST = 15'd75;
	localparam logic [15:0] DUTY_FULL_RST  = 16'd31249;
	localparam logic [16:0] DONE_SEC_RST   = 17'd300;

	localparam logic [16:0] DAY_SECONDS = 17'd86400;

	// Last second of each phase before cooling.
	localparam logic [16:0] END_PREHEAT = 17'd90;
	localparam logic [16:0] END_SOAK    = 17'd210;
	localparam logic [16:0] END_RISE    = 17'd240;
	localparam logic [16:0] END_FALL    = 17'd270;

	// Setpoint line coefficients, folded to slope * t + offset (mod 2^16).
	localparam logic [15:0] SP_OFF       = 16'd250;
	localparam logic [15:0] SP_PRE_K     = 16'd13;
	localparam logic [15:0] SP_PRE_OFS   = 16'd250;
	localparam logic [15:0] SP_SOAK_K    = 16'd3;
	localparam logic [15:0] SP_SOAK_OFS  = 16'd1180;
	localparam logic [15:0] SP_RISE_K    = 16'd12;
	localparam logic [15:0] SP_RISE_OFS  = 16'd690;
	localparam logic [15:0] SP_FALL_K    = 16'd12;
	localparam logic [15:0] SP_FALL_OFS  = 16'd5080;
	localparam logic [15:0] SP_COOL_K    = 16'd18;
	localparam logic [15:0] SP_COOL_OFS  = 16'd6690;

endpackage

`default_nettype wire

>>> rtl/rpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpc_cfg_regs: configuration registers
// Holds gain, full-on error, full duty and buzzer time, written one at a
// time through the configuration request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rpc_pkg::cfg_idx_t   cfg_index,
	input  logic [16:0]         cfg_data,
	output rpc_pkg::rpc_cfg_t   cfg
);
	import rpc_pkg::*;

	rpc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain          <= GAIN_RST;
			cfg_q.full_on_error <= FULL_ERROR_RST;
			cfg_q.duty_full     <= DUTY_FULL_RST;
			cfg_q.done_seconds  <= DONE_SEC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN:       cfg_q.gain          <= cfg_data[14:0];
				CFG_FULL_ERROR: cfg_q.full_on_error <= cfg_data[14:0];
				CFG_DUTY_FULL:  cfg_q.duty_full     <= cfg_data[15:0];
				CFG_DONE_SEC:   cfg_q.done_seconds  <= cfg_data;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/rpc_step.sv
// ----------------------------------------------------------------------------
// rpc_step: next-state logic for one event
// Computes the controller state that follows the current state and one
// tick, sample, start or stop request.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_step (
	input  rpc_pkg::rpc_state_t  cur,
	input  rpc_pkg::rpc_cfg_t    cfg,
	input  rpc_pkg::kind_t       kind,
	input  logic signed [15:0]   temperature,
	output rpc_pkg::rpc_state_t  nxt
);
	import rpc_pkg::*;

	logic [15:0]        t16;
	logic signed [15:0] sp;
	logic signed [16:0] err;
	logic signed [31:0] prod;
	logic signed [15:0] gain_s;
	logic [15:0]        duty_new;
	logic [16:0]        sec_inc;
	phase_t             tick_phase;

	// The setpoint is kept to 16 bits, so the line is evaluated modulo 2^16.
	assign t16 = cur.seconds[15:0];

	always_comb begin
		unique case (cur.phase)
			PH_OFF:     sp = SP_OFF;
			PH_PREHEAT: sp = t16 * SP_PRE_K + SP_PRE_OFS;
			PH_SOAK:    sp = t16 * SP_SOAK_K + SP_SOAK_OFS;
			PH_RISE:    sp = t16 * SP_RISE_K - SP_RISE_OFS;
			PH_FALL:    sp = SP_FALL_OFS - t16 * SP_FALL_K;
			PH_COOL:    sp = SP_COOL_OFS - t16 * SP_COOL_K;
			default:    sp = temperature;
		endcase
	end

	// Error and product are wide enough to be exact.
	assign err    = 17'(sp) - 17'(temperature);
	assign gain_s = $signed({1'b0, cfg.gain});
	assign prod   = 32'(gain_s) * 32'(err);

	always_comb begin
		priority if (cur.phase == PH_OFF) begin
			duty_new = '0;
		end else if (err > $signed({2'b00, cfg.full_on_error})
				|| prod > $signed({16'd0, cfg.duty_full})) begin
			duty_new = cfg.duty_full;
		end else if (err < 0) begin
			duty_new = '0;
		end else begin
			duty_new = prod[15:0];
		end
	end

	assign sec_inc = (cur.seconds >= DAY_SECONDS) ? '0 : cur.seconds + 17'd1;

	always_comb begin
		priority if (sec_inc <= END_PREHEAT) begin
			tick_phase = PH_PREHEAT;
		end else if (sec_inc <= END_SOAK) begin
			tick_phase = PH_SOAK;
		end else if (sec_inc <= END_RISE) begin
			tick_phase = PH_RISE;
		end else if (sec_inc <= END_FALL) begin
			tick_phase = PH_FALL;
		end else begin
			tick_phase = PH_COOL;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (kind)
			KIND_TICK: begin
				if (cur.phase != PH_OFF) begin
					nxt.seconds = sec_inc;
					nxt.phase   = tick_phase;
					if (tick_phase == PH_COOL && sec_inc > cfg.done_seconds) begin
						nxt.buzzer = 1'b1;
					end
				end
			end
			KIND_SAMPLE: begin
				nxt.target = sp;
				nxt.duty   = duty_new;
			end
			KIND_START: begin
				if (cur.phase == PH_OFF) begin
					nxt.phase   = PH_PREHEAT;
					nxt.seconds = '0;
				end
			end
			KIND_STOP: begin
				nxt.phase  = PH_OFF;
				nxt.buzzer = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/reflow_profile_controller.sv
// ----------------------------------------------------------------------------
// reflow_profile_controller: reflow oven profile and relay duty controller
// Takes tick, sample, start and stop requests and reports the oven state
// after each one.
// ----------------------------------------------------------------------------
// Every input request yields exactly one result request that carries the
// controller state after that event: relay duty, oven phase, elapsed
// seconds, latest setpoint and buzzer flag. The block accepts one request
// per clock cycle while the output is not stalled: the request is first
// captured in an input register, then the event logic updates the state
// register, which also serves as the result register. The state update is a
// loop closed through that register, and that loop sets the rate of one
// event per cycle. A result waiting for the consumer holds the event in the
// input register, so one further request is still taken while the output is
// stalled.
// Configuration registers come out of reset with their default values and
// may be written at any time the block is idle; the configuration channel
// is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module reflow_profile_controller (
	input  logic               clk,
	input  logic               arst_n,
	// Event requests.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [15:0] temperature,
	// Result requests.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        duty,
	output logic [2:0]         phase,
	output logic [16:0]        elapsed,
	output logic signed [15:0] setpoint,
	output logic               buzzer,
	// Configuration writes.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import rpc_pkg::*;

	rpc_cfg_t   cfg;
	rpc_state_t st_q;
	rpc_state_t st_next;

	logic               valid_s1;
	kind_t              kind_s1;
	logic signed [15:0] temp_s1;
	logic               out_valid_q;
	logic               advance_s1;

	rpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_idx_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The captured event moves on when the result slot is empty or is
	// being emptied in this cycle.
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_TICK;
			temp_s1 <= '0;
		end else if (in_valid && in_ready) begin
			kind_s1 <= kind_t'(kind);
			temp_s1 <= temperature;
		end
	end

	rpc_step u_step (
		.cur         (st_q),
		.cfg         (cfg),
		.kind        (kind_s1),
		.temperature (temp_s1),
		.nxt         (st_next)
	);

	// The state only changes when a result is produced, and a new result
	// is only produced once the previous one has been taken, so the state
	// register doubles as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase   <= PH_OFF;
			st_q.seconds <= '0;
			st_q.duty    <= '0;
			st_q.target  <= '0;
			st_q.buzzer  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance_s1) begin
				st_q        <= st_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = st_q.duty;
	assign phase     = st_q.phase;
	assign elapsed   = st_q.seconds;
	assign setpoint  = st_q.target;
	assign buzzer    = st_q.buzzer;

	// The time counter wraps and never passes one day.
	a_elapsed_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seconds <= DAY_SECONDS)
		else $error("elapsed seconds beyond one day");

	// The state may only move when an event is turned into a result.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance_s1 |=> $stable(st_q))
		else $error("state changed without an event");

	// Input back-pressure only comes from a full input register behind a
	// stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without cause");

	// Every event taken into the state produces a visible result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> out_valid)
		else $error("event consumed without result");

endmodule

`default_nettype wire
